>>> sv/rat_pkg.sv
// Shared constants, types and sign-magnitude helpers for the rational accumulator ALU.
`default_nettype none
package rat_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int MAG_WIDTH     = 2 * VALUE_WIDTH;
   localparam int FIELD_WIDTH   = 32;
   localparam int OPCODE_WIDTH  = 3;
   localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH);
   localparam int MUL_CNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int DIV_CNT_WIDTH = $clog2(MAG_WIDTH + 1);

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_LOAD = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } opcode_type;

   typedef struct packed {
      logic                 neg;
      logic [MAG_WIDTH-1:0] mag;
   } smag_type;

   // magnitude of a two's complement value, unsigned
   function automatic logic [VALUE_WIDTH-1:0] mag_of(input logic [VALUE_WIDTH-1:0] x);
      return x[VALUE_WIDTH-1] ? (~x + 1'b1) : x;
   endfunction

   function automatic smag_type to_smag(input logic [VALUE_WIDTH:0] v);
      smag_type               r;
      logic [VALUE_WIDTH:0]   m;
      m = v[VALUE_WIDTH] ? (~v + 1'b1) : v;
      r.neg = v[VALUE_WIDTH];
      r.mag = MAG_WIDTH'(m);
      return r;
   endfunction

   function automatic smag_type negate(input smag_type x);
      smag_type r;
      r.mag = x.mag;
      r.neg = !x.neg && (x.mag != '0);
      return r;
   endfunction

   function automatic smag_type sm_sum(input smag_type x, input smag_type y);
      smag_type r;
      if (x.neg == y.neg) begin
         r.mag = x.mag + y.mag;
         r.neg = x.neg;
      end else if (x.mag >= y.mag) begin
         r.mag = x.mag - y.mag;
         r.neg = x.neg;
      end else begin
         r.mag = y.mag - x.mag;
         r.neg = y.neg;
      end
      if (r.mag == '0) r.neg = 1'b0;
      return r;
   endfunction

   function automatic logic fits(input smag_type x);
      logic [MAG_WIDTH-1:0] lim;
      lim = MAG_WIDTH'(1) << (VALUE_WIDTH - 1);
      return x.neg ? (x.mag <= lim) : (x.mag < lim);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] pack(input smag_type x);
      logic [MAG_WIDTH-1:0] t;
      t = x.neg ? (~x.mag + 1'b1) : x.mag;
      return t[VALUE_WIDTH-1:0];
   endfunction

endpackage
`default_nettype wire

>>> sv/rational_accumulator_alu.sv
// Rational accumulator ALU: one numerator/denominator pair updated per input item.
//
// req_* channel carries one operation: opcode in req_tuser, the operand numerator and
// denominator in req_tdata. Each accepted item yields exactly one rsp_* item with the
// reduced accumulator in rsp_tdata and the zero-denominator and overflow flags in
// rsp_tuser.
// One item at a time: req_tready is high only while the sequencer is idle. The cost of
// an item is set by the shared shift-add multiplier (up to three products for add and
// subtract), the binary gcd loop (one compare, subtract or shift per cycle) and two passes
// of the restoring divider. Loads with a zero denominator and unused opcodes skip the gcd
// loop and the divider.
// The result sits in an output register; a new item is accepted while it waits. If
// the receiver stalls, the next result holds in the sequencer until the register frees.
// Reset (synchronous, active high) clears the accumulator to 0/0 and empties the
// output register.
`default_nettype none
module rational_accumulator_alu (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,  // operand_num [31:0], operand_den [63:32]
   input  wire logic [7:0]  req_tuser,  // opcode [2:0], zero fill [7:3]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // result_num [31:0], result_den [63:32]
   output logic [7:0]       rsp_tuser   // zero_denominator [0], overflow [1], zero fill
);

   localparam int W  = rat_pkg::VALUE_WIDTH;
   localparam int M  = rat_pkg::MAG_WIDTH;
   localparam int FW = rat_pkg::FIELD_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_MUL_P, S_MUL_Q, S_MUL_D, S_SUM,
      S_CHECK, S_GCD, S_DIV_N, S_DIV_D, S_FIN
   } state_type;

   state_type                         state_ff;
   logic [rat_pkg::OPCODE_WIDTH-1:0]  op_ff;
   logic [W-1:0]                      bn_ff, bd_ff;
   logic [W-1:0]                      acc_num_ff, acc_den_ff;
   rat_pkg::smag_type                 p_ff, q_ff, n_ff, d_ff;
   logic [M-1:0]                      ga_ff, gb_ff, g_ff;
   logic [rat_pkg::SHIFT_WIDTH-1:0]   gk_ff;
   logic                              zden_ff;
   logic                              mul_start_ff, div_start_ff;
   logic [W-1:0]                      mul_a_ff, mul_b_ff;
   logic                              mul_sgn_ff;
   logic [M-1:0]                      div_num_ff, div_den_ff;
   logic                              rsp_valid_ff;
   logic [FW-1:0]                     rsp_num_ff, rsp_den_ff;
   logic                              rsp_zden_ff, rsp_ovf_ff;

   logic                              mul_done, div_done;
   logic [M-1:0]                      mul_prod, div_quo;
   rat_pkg::smag_type                 prod_sm;
   logic                              op_valid, op_addsub;
   logic                              out_free;

   rat_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (mul_a_ff),
      .b       (mul_b_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   rat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      prod_sm.mag = mul_prod;
      prod_sm.neg = mul_sgn_ff && (mul_prod != '0);
   end

   assign op_valid   = op_ff inside {rat_pkg::OP_LOAD, rat_pkg::OP_ADD, rat_pkg::OP_SUB,
                                     rat_pkg::OP_MUL, rat_pkg::OP_DIV};
   assign op_addsub  = op_ff inside {rat_pkg::OP_ADD, rat_pkg::OP_SUB};
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_num_ff   <= '0;
         acc_den_ff   <= '0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff    <= req_tuser[rat_pkg::OPCODE_WIDTH-1:0];
                  bn_ff    <= req_tdata[W-1:0];
                  bd_ff    <= req_tdata[FW+W-1:FW];
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               case (op_ff)
                  rat_pkg::OP_LOAD: begin
                     n_ff     <= rat_pkg::to_smag({bn_ff[W-1], bn_ff});
                     d_ff     <= rat_pkg::to_smag({bd_ff[W-1], bd_ff});
                     state_ff <= S_CHECK;
                  end
                  rat_pkg::OP_ADD, rat_pkg::OP_SUB: begin
                     if (acc_den_ff == bd_ff) begin
                        // equal denominators: combine numerators directly
                        n_ff <= rat_pkg::to_smag((op_ff == rat_pkg::OP_ADD)
                                   ? ({acc_num_ff[W-1], acc_num_ff} + {bn_ff[W-1], bn_ff})
                                   : ({acc_num_ff[W-1], acc_num_ff} - {bn_ff[W-1], bn_ff}));
                        d_ff     <= rat_pkg::to_smag({acc_den_ff[W-1], acc_den_ff});
                        state_ff <= S_CHECK;
                     end else begin
                        mul_a_ff     <= rat_pkg::mag_of(acc_num_ff);
                        mul_b_ff     <= rat_pkg::mag_of(bd_ff);
                        mul_sgn_ff   <= acc_num_ff[W-1] ^ bd_ff[W-1];
                        mul_start_ff <= 1'b1;
                        state_ff     <= S_MUL_P;
                     end
                  end
                  rat_pkg::OP_MUL: begin
                     mul_a_ff     <= rat_pkg::mag_of(acc_num_ff);
                     mul_b_ff     <= rat_pkg::mag_of(bn_ff);
                     mul_sgn_ff   <= acc_num_ff[W-1] ^ bn_ff[W-1];
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_MUL_P;
                  end
                  rat_pkg::OP_DIV: begin
                     mul_a_ff     <= rat_pkg::mag_of(acc_num_ff);
                     mul_b_ff     <= rat_pkg::mag_of(bd_ff);
                     mul_sgn_ff   <= acc_num_ff[W-1] ^ bd_ff[W-1];
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_MUL_P;
                  end
                  default: state_ff <= S_FIN;
               endcase
            end
            S_MUL_P: begin
               if (mul_done) begin
                  p_ff         <= prod_sm;
                  mul_start_ff <= 1'b1;
                  if (op_addsub) begin
                     mul_a_ff   <= rat_pkg::mag_of(bn_ff);
                     mul_b_ff   <= rat_pkg::mag_of(acc_den_ff);
                     mul_sgn_ff <= bn_ff[W-1] ^ acc_den_ff[W-1];
                     state_ff   <= S_MUL_Q;
                  end else begin
                     mul_a_ff   <= rat_pkg::mag_of(acc_den_ff);
                     mul_b_ff   <= rat_pkg::mag_of((op_ff == rat_pkg::OP_DIV) ? bn_ff : bd_ff);
                     mul_sgn_ff <= acc_den_ff[W-1] ^
                                   ((op_ff == rat_pkg::OP_DIV) ? bn_ff[W-1] : bd_ff[W-1]);
                     state_ff   <= S_MUL_D;
                  end
               end
            end
            S_MUL_Q: begin
               if (mul_done) begin
                  q_ff         <= prod_sm;
                  mul_a_ff     <= rat_pkg::mag_of(acc_den_ff);
                  mul_b_ff     <= rat_pkg::mag_of(bd_ff);
                  mul_sgn_ff   <= acc_den_ff[W-1] ^ bd_ff[W-1];
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_MUL_D;
               end
            end
            S_MUL_D: begin
               if (mul_done) begin
                  d_ff     <= prod_sm;
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               if (op_addsub)
                  n_ff <= rat_pkg::sm_sum(p_ff, (op_ff == rat_pkg::OP_SUB)
                                                ? rat_pkg::negate(q_ff) : q_ff);
               else
                  n_ff <= p_ff;
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               zden_ff <= (d_ff.mag == '0);
               ga_ff   <= n_ff.mag;
               gb_ff   <= d_ff.mag;
               gk_ff   <= '0;
               // zero denominator: skip reduction
               state_ff <= (d_ff.mag == '0) ? S_FIN : S_GCD;
            end
            S_GCD: begin
               if (ga_ff == '0) begin
                  g_ff         <= gb_ff << gk_ff;
                  div_num_ff   <= n_ff.mag;
                  div_den_ff   <= gb_ff << gk_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_N;
               end else if (!ga_ff[0] && !gb_ff[0]) begin
                  ga_ff <= ga_ff >> 1;
                  gb_ff <= gb_ff >> 1;
                  gk_ff <= gk_ff + 1'b1;
               end else if (!ga_ff[0]) begin
                  ga_ff <= ga_ff >> 1;
               end else if (!gb_ff[0]) begin
                  gb_ff <= gb_ff >> 1;
               end else if (ga_ff >= gb_ff) begin
                  ga_ff <= ga_ff - gb_ff;
               end else begin
                  gb_ff <= gb_ff - ga_ff;
               end
            end
            S_DIV_N: begin
               if (div_done) begin
                  n_ff.mag     <= div_quo;
                  if (div_quo == '0) n_ff.neg <= 1'b0;
                  div_num_ff   <= d_ff.mag;
                  div_den_ff   <= g_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_D;
               end
            end
            S_DIV_D: begin
               if (div_done) begin
                  d_ff.mag <= div_quo;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (op_valid) begin
                     acc_num_ff  <= rat_pkg::pack(n_ff);
                     acc_den_ff  <= rat_pkg::pack(d_ff);
                     rsp_num_ff  <= FW'(signed'(rat_pkg::pack(n_ff)));
                     rsp_den_ff  <= FW'(signed'(rat_pkg::pack(d_ff)));
                     rsp_zden_ff <= zden_ff;
                     rsp_ovf_ff  <= !rat_pkg::fits(n_ff) || !rat_pkg::fits(d_ff);
                  end else begin
                     rsp_num_ff  <= FW'(signed'(acc_num_ff));
                     rsp_den_ff  <= FW'(signed'(acc_den_ff));
                     rsp_zden_ff <= (acc_den_ff == '0);
                     rsp_ovf_ff  <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_den_ff, rsp_num_ff};
   assign rsp_tuser  = {6'b0, rsp_ovf_ff, rsp_zden_ff};

   a_zden_means_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[63:32] == '0)
      else $error("zero-denominator flag with nonzero denominator");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("sequencer idle right after accepting an item");

   a_gcd_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GCD |-> gb_ff != '0)
      else $error("gcd operand reached zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> sv/rat_mul.sv
// Shift-add multiplier: unsigned magnitudes, one multiplier bit per cycle.
`default_nettype none
module rat_mul (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [rat_pkg::VALUE_WIDTH-1:0] a,
   input  wire logic [rat_pkg::VALUE_WIDTH-1:0] b,
   output logic                                 done,
   output logic [rat_pkg::MAG_WIDTH-1:0]        product
);

   logic [rat_pkg::MAG_WIDTH-1:0]     acc_ff;
   logic [rat_pkg::MAG_WIDTH-1:0]     mcand_ff;
   logic [rat_pkg::VALUE_WIDTH-1:0]   mplier_ff;
   logic [rat_pkg::MUL_CNT_WIDTH-1:0] cnt_ff;
   logic                              busy_ff;
   logic                              done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            acc_ff    <= '0;
            mcand_ff  <= rat_pkg::MAG_WIDTH'(a);
            mplier_ff <= b;
            cnt_ff    <= '0;
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            if (mplier_ff[0]) acc_ff <= acc_ff + mcand_ff;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
            cnt_ff    <= cnt_ff + 1'b1;
            if (cnt_ff == rat_pkg::MUL_CNT_WIDTH'(rat_pkg::VALUE_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

>>> sv/rat_div.sv
// Restoring divider: unsigned, one quotient bit per cycle.
`default_nettype none
module rat_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rat_pkg::MAG_WIDTH-1:0] dividend,
   input  wire logic [rat_pkg::MAG_WIDTH-1:0] divisor,
   output logic                               done,
   output logic [rat_pkg::MAG_WIDTH-1:0]      quotient
);

   logic [rat_pkg::MAG_WIDTH:0]       rem_ff;
   logic [rat_pkg::MAG_WIDTH-1:0]     quo_ff;
   logic [rat_pkg::MAG_WIDTH-1:0]     dsr_ff;
   logic [rat_pkg::DIV_CNT_WIDTH-1:0] cnt_ff;
   logic                              busy_ff;
   logic                              done_ff;
   logic [rat_pkg::MAG_WIDTH:0]       shifted;
   logic [rat_pkg::MAG_WIDTH:0]       diff;

   assign shifted = {rem_ff[rat_pkg::MAG_WIDTH-1:0], quo_ff[rat_pkg::MAG_WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!diff[rat_pkg::MAG_WIDTH]) begin
               rem_ff <= diff;
               quo_ff <= {quo_ff[rat_pkg::MAG_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff <= shifted;
               quo_ff <= {quo_ff[rat_pkg::MAG_WIDTH-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == rat_pkg::DIV_CNT_WIDTH'(rat_pkg::MAG_WIDTH - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire
